@@ rtl/plid_pkg.sv @@
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and constants for the positional list insert/delete block.
// ----------------------------------------------------------------------------
`default_nettype none

package plid_pkg;

   localparam int DEPTH_DEFAULT = 16;

   // Field widths fixed by the item format
   localparam int POS_W = 8;
   localparam int VAL_W = 32;
   localparam int LEN_W = 5;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_DELETE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PUT,
      ST_EMIT,
      ST_REPLY
   } state_type;

endpackage

`default_nettype wire

@@ rtl/positional_list_insert_delete_top.sv @@
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top
// Ordered list of signed values with insert and delete at a 1-based position.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation item (action, position, new_value) under a
//   valid/ready handshake. rsp_* returns the list after each successful
//   operation, one element per item, rsp_last on the final one. A rejected
//   position or an insert into a full list returns a single item with the
//   status code; an emptied list returns a single item with element_valid low.
// Timing:
//   One operation at a time; req_ready is high only while idle. The list
//   lives in a single memory with one write and registered reads, so the
//   entries behind the position are moved one at a time, an insert then
//   writes the new value, and the list is then streamed at one element per
//   cycle. A stalled receiver holds the output register and pauses the
//   stream; the next item may be accepted while the final result waits.
// Reset:
//   Clears the fill count and the control state; list contents are not
//   cleared, as entries at or above the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete_top #(
   parameter int DEPTH = plid_pkg::DEPTH_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,

   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_action,
   input  wire  [plid_pkg::POS_W-1:0]       req_position,
   input  wire  signed [plid_pkg::VAL_W-1:0] req_new_value,

   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic signed [plid_pkg::VAL_W-1:0] rsp_element_value,
   output logic                             rsp_element_valid,
   output logic [plid_pkg::LEN_W-1:0]       rsp_list_length,
   output logic                             rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = plid_pkg::POS_W;
   localparam int VW = plid_pkg::VAL_W;
   localparam int LW = plid_pkg::LEN_W;

   // List memory
   logic [VW-1:0] mem [DEPTH];

   plid_pkg::state_type  state_ff, state_in;
   plid_pkg::action_type act_ff, act_in;
   plid_pkg::status_type reply_status_ff, reply_status_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [VW-1:0] val_ff, val_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic          more_ff, more_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [VW-1:0] rd_data_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   plid_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_elem_ff, rsp_elem_in;
   logic [LW-1:0]        rsp_len_ff, rsp_len_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [VW-1:0]        rsp_value_ff;

   logic          accept;
   logic          slot_free;
   logic [PW:0]   pos_ext;
   logic [PW:0]   cnt_ext;
   logic [PW-1:0] pos_m1;
   logic          ins_bad, del_bad, is_full;
   logic          ins_append, del_tail;
   logic [AW-1:0] last_idx;
   logic          end_rd;
   logic          shift_done;
   logic          emit_load, emit_last;
   logic          reply_load;
   logic          rd_en;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [VW-1:0] mem_wd;
   logic [CW+LW-1:0] len_ext;

   // ---------------------------------------------------------------------
   // Decode and checks
   // ---------------------------------------------------------------------
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign pos_ext    = (PW + 1)'(req_position);
   assign cnt_ext    = (PW + 1)'(count_ff);
   assign pos_m1     = req_position - PW'(1);
   assign ins_bad    = (req_position == '0) || (pos_ext > cnt_ext + (PW + 1)'(1));
   assign del_bad    = (req_position == '0) || (pos_ext > cnt_ext);
   assign is_full    = (count_ff == CW'(DEPTH));
   assign ins_append = (pos_ext == cnt_ext + (PW + 1)'(1));
   assign del_tail   = (pos_ext == cnt_ext);
   assign last_idx   = AW'(count_ff - CW'(1));

   assign end_rd     = (act_ff == plid_pkg::ACT_INSERT) ? (cur_ff == pos_ff)
                                                        : (cur_ff == last_idx);
   assign shift_done = pend_ff && !more_ff;
   assign emit_last  = (CW'(idx_ff) + CW'(1) == count_ff);
   assign emit_load  = (state_ff == plid_pkg::ST_EMIT) && slot_free;
   assign reply_load = (state_ff == plid_pkg::ST_REPLY) && slot_free;
   assign rd_en      = (state_ff == plid_pkg::ST_SHIFT) && more_ff;
   assign len_ext    = (CW + LW)'(count_ff);

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         plid_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_action == plid_pkg::ACT_INSERT) begin
                  if (ins_bad || is_full) begin
                     state_in = plid_pkg::ST_REPLY;
                  end else if (ins_append) begin
                     state_in = plid_pkg::ST_PUT;
                  end else begin
                     state_in = plid_pkg::ST_SHIFT;
                  end
               end else begin
                  if (del_bad) begin
                     state_in = plid_pkg::ST_REPLY;
                  end else if (del_tail) begin
                     state_in = (count_ff == CW'(1)) ? plid_pkg::ST_REPLY
                                                     : plid_pkg::ST_EMIT;
                  end else begin
                     state_in = plid_pkg::ST_SHIFT;
                  end
               end
            end
         end
         plid_pkg::ST_SHIFT: begin
            if (shift_done) begin
               state_in = (act_ff == plid_pkg::ACT_INSERT) ? plid_pkg::ST_PUT
                                                           : plid_pkg::ST_EMIT;
            end
         end
         plid_pkg::ST_PUT: begin
            state_in = plid_pkg::ST_EMIT;
         end
         plid_pkg::ST_EMIT: begin
            if (slot_free && emit_last) begin
               state_in = plid_pkg::ST_IDLE;
            end
         end
         plid_pkg::ST_REPLY: begin
            if (slot_free) begin
               state_in = plid_pkg::ST_IDLE;
            end
         end
         default: state_in = plid_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Outputs and datapath
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready       = (state_ff == plid_pkg::ST_IDLE);
      act_in          = act_ff;
      pos_in          = pos_ff;
      val_in          = val_ff;
      count_in        = count_ff;
      reply_status_in = reply_status_ff;
      cur_in          = cur_ff;
      wa_in           = wa_ff;
      more_in         = more_ff;
      pend_in         = 1'b0;
      idx_in          = '0;
      mem_we          = 1'b0;
      mem_wa          = wa_ff;
      mem_wd          = rd_data_ff;

      unique case (state_ff)
         plid_pkg::ST_IDLE: begin
            if (accept) begin
               act_in          = plid_pkg::action_type'(req_action);
               pos_in          = pos_m1[AW-1:0];
               val_in          = req_new_value;
               reply_status_in = plid_pkg::STATUS_DONE;
               more_in         = 1'b1;
               if (req_action == plid_pkg::ACT_INSERT) begin
                  cur_in = last_idx;
                  if (ins_bad) begin
                     reply_status_in = plid_pkg::STATUS_BADPOS;
                  end else if (is_full) begin
                     reply_status_in = plid_pkg::STATUS_FULL;
                  end
               end else begin
                  cur_in = req_position[AW-1:0];
                  if (del_bad) begin
                     reply_status_in = plid_pkg::STATUS_BADPOS;
                  end else if (del_tail) begin
                     count_in = count_ff - CW'(1);
                  end
               end
            end
         end
         plid_pkg::ST_SHIFT: begin
            // Read one entry ahead, write the previous read to its new slot
            if (more_ff) begin
               pend_in = 1'b1;
               more_in = !end_rd;
               if (act_ff == plid_pkg::ACT_INSERT) begin
                  cur_in = cur_ff - AW'(1);
                  wa_in  = cur_ff + AW'(1);
               end else begin
                  cur_in = cur_ff + AW'(1);
                  wa_in  = cur_ff - AW'(1);
               end
            end
            mem_we = pend_ff;
            if (shift_done && act_ff == plid_pkg::ACT_DELETE) begin
               count_in = count_ff - CW'(1);
            end
         end
         plid_pkg::ST_PUT: begin
            mem_we   = 1'b1;
            mem_wa   = pos_ff;
            mem_wd   = val_ff;
            count_in = count_ff + CW'(1);
         end
         plid_pkg::ST_EMIT: begin
            idx_in = emit_load ? idx_ff + AW'(1) : idx_ff;
         end
         plid_pkg::ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = plid_pkg::STATUS_DONE;
         rsp_elem_in   = 1'b1;
         rsp_len_in    = len_ext[LW-1:0];
         rsp_last_in   = emit_last;
      end else if (reply_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = reply_status_ff;
         rsp_elem_in   = 1'b0;
         rsp_len_in    = len_ext[LW-1:0];
         rsp_last_in   = 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_value = rsp_elem_ff ? rsp_value_ff : '0;
   assign rsp_element_valid = rsp_elem_ff;
   assign rsp_list_length   = rsp_len_ff;
   assign rsp_last          = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plid_pkg::ST_IDLE;
         count_ff     <= '0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         more_ff      <= more_in;
         pend_ff      <= pend_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      pos_ff          <= pos_in;
      val_ff          <= val_in;
      reply_status_ff <= reply_status_in;
      cur_ff          <= cur_in;
      wa_ff           <= wa_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_elem_ff     <= rsp_elem_in;
      rsp_len_ff      <= rsp_len_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // List memory: one write port, shift read and stream read registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[cur_ff];
      end
      if (emit_load) begin
         rsp_value_ff <= mem[idx_ff];
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_pend_in_shift: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == plid_pkg::ST_SHIFT)
      else $error("pending shift data outside shift state");

   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == plid_pkg::ST_PUT |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      emit_load |-> CW'(idx_ff) < count_ff)
      else $error("stream index beyond fill count");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff != plid_pkg::ST_IDLE |-> !req_ready)
      else $error("ready while an operation is in progress");
`endif

endmodule

`default_nettype wire
